FILE: rtl/core/dmm_pkg.sv
// Shared types and constants for the dense matrix multiply block.
// No dependencies; imported by the top level.
package dmm_pkg;

    // Width of the exact Q22.16 dot product on the result channel.
    localparam int SUM_BITS = 38;

    // Fixed widths of the item fields.
    localparam int OP_BITS  = 2;
    localparam int IDX_BITS = 6;
    localparam int POS_BITS = 3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_COL_COUNT   = 2'd1;
    localparam logic [1:0] CFG_INNER_DEPTH = 2'd2;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_START   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Tag that travels with each MAC step down the pipeline.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                lastk;
        logic                lastel;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } t_tag;

endpackage

FILE: rtl/core/dmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/dense_matrix_multiply.sv
// Dense matrix multiply C = A x B on signed Q8.8 elements, exact Q22.16 sums.
// Depends on dmm_pkg and dmm_ram.
//
// Input channel (s_axis): one item per handshake; op selects a write of an A
// element, a write of a B element, or start. Writes store into the A or B
// RAM; drop a write whose index lies outside the configured sizes. Reading
// an element never written is undefined.
// Start: walk every C element in row-major order and emit one result item per
// element on m_axis, tlast set on the final one.
// Timing: one MAC step reads one A and one B element per cycle while the
// output does not stall, so a run of N = row_count * col_count * inner_depth
// steps issues them in order after the start item. Results leave one per C
// element, after its last step; each passes from the RAM read register
// through the product register into the output register. tready stays low
// until the last step has left the read and product registers.
// Stall: while a result waits and m_axis_tready is low, hold the whole
// read/multiply/accumulate pipeline.
// Configuration: write row_count, col_count, inner_depth only while idle;
// values saturate into 1..maximum, rows and cols from data bits 3:0. Reset
// (synchronous, active low): sizes to max, control state clears, RAM kept.
module dense_matrix_multiply
    import dmm_pkg::*;
#(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int MAX_DEPTH  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    // {element_value, col_index, row_index, op} from bit 0 up, zero padded
    input  logic [((3*IDX_BITS/3*2+OP_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // {dot_sum, out_col, out_row} from bit 0 up, zero padded
    output logic [((2*POS_BITS+SUM_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                           m_axis_tlast,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    input  logic                                           i_cfg_wr_en,
    input  logic [1:0]                                     i_cfg_index,
    input  logic [6:0]                                     i_cfg_data
);

    localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DB    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int DCW   = $clog2(MAX_DEPTH + 1);
    localparam int OUT_W = ((2*POS_BITS + SUM_BITS + 7) / 8) * 8;
    localparam int OUT_B = 2*POS_BITS + SUM_BITS;
    localparam int A_DEPTH = 2**(RB + DB);
    localparam int B_DEPTH = 2**(DB + CB);
    localparam int PW    = 2 * VALUE_BITS;

    // Input fields
    t_op                  w_op;
    logic [IDX_BITS-1:0]  w_row;
    logic [IDX_BITS-1:0]  w_col;
    logic [VALUE_BITS-1:0] w_value;
    logic                 w_in_acc;

    assign w_op    = t_op'(s_axis_tdata[OP_BITS-1:0]);
    assign w_row   = s_axis_tdata[OP_BITS +: IDX_BITS];
    assign w_col   = s_axis_tdata[OP_BITS+IDX_BITS +: IDX_BITS];
    assign w_value = s_axis_tdata[OP_BITS+2*IDX_BITS +: VALUE_BITS];

    // Configuration registers
    logic [RCW-1:0] r_rows;
    logic [CCW-1:0] r_cols;
    logic [DCW-1:0] r_depth;
    logic [RCW-1:0] w_rows_sat;
    logic [CCW-1:0] w_cols_sat;
    logic [DCW-1:0] w_depth_sat;

    always_comb begin
        // Saturate written sizes into 1..maximum
        if (i_cfg_data[3:0] == 4'd0) begin
            w_rows_sat = RCW'(1);
        end else if (32'(i_cfg_data[3:0]) > MAX_ROWS) begin
            w_rows_sat = RCW'(MAX_ROWS);
        end else begin
            w_rows_sat = RCW'(i_cfg_data[3:0]);
        end
        if (i_cfg_data[3:0] == 4'd0) begin
            w_cols_sat = CCW'(1);
        end else if (32'(i_cfg_data[3:0]) > MAX_COLS) begin
            w_cols_sat = CCW'(MAX_COLS);
        end else begin
            w_cols_sat = CCW'(i_cfg_data[3:0]);
        end
        if (i_cfg_data == 7'd0) begin
            w_depth_sat = DCW'(1);
        end else if (32'(i_cfg_data) > MAX_DEPTH) begin
            w_depth_sat = DCW'(MAX_DEPTH);
        end else begin
            w_depth_sat = DCW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= RCW'(MAX_ROWS);
            r_cols  <= CCW'(MAX_COLS);
            r_depth <= DCW'(MAX_DEPTH);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:   r_rows  <= w_rows_sat;
                CFG_COL_COUNT:   r_cols  <= w_cols_sat;
                CFG_INNER_DEPTH: r_depth <= w_depth_sat;
                default: ; // no register at this index: drop the write
            endcase
        end
    end

    // Control state
    t_state        r_state, n_state;
    logic [RB-1:0] r_i, n_i;
    logic [CB-1:0] r_j, n_j;
    logic [DB-1:0] r_k, n_k;
    t_tag          r_s1, r_s2;
    t_tag          w_tag;
    logic          w_issue;
    logic          w_adv;
    logic          w_last_i, w_last_j, w_last_k;

    // Pipeline payload
    logic [VALUE_BITS-1:0]        w_a_data, w_b_data;
    logic signed [PW-1:0]         r_prod;
    logic signed [63:0]           w_prod_wide;
    logic [SUM_BITS-1:0]          r_acc;
    logic [SUM_BITS-1:0]          w_sum;
    logic                         r_out_valid;
    logic [POS_BITS-1:0]          r_out_row, r_out_col;
    logic [SUM_BITS-1:0]          r_out_sum;
    logic                         r_out_last;

    // Store writes
    logic              w_a_we, w_b_we;
    logic [RB+DB-1:0]  w_a_waddr, w_a_raddr;
    logic [DB+CB-1:0]  w_b_waddr, w_b_raddr;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Hold the pipeline whenever a result waits and the receiver stalls
    assign w_adv = !r_out_valid || m_axis_tready;

    assign w_a_we = w_in_acc && (w_op == OP_WRITE_A) &&
                    (32'(w_row) < 32'(r_rows)) && (32'(w_col) < 32'(r_depth));
    assign w_b_we = w_in_acc && (w_op == OP_WRITE_B) &&
                    (32'(w_row) < 32'(r_depth)) && (32'(w_col) < 32'(r_cols));

    assign w_a_waddr = {RB'(w_row), DB'(w_col)};
    assign w_b_waddr = {DB'(w_row), CB'(w_col)};
    assign w_a_raddr = {r_i, r_k};
    assign w_b_raddr = {r_k, r_j};

    dmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (A_DEPTH)
    ) u_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_a_we),
        .i_wr_addr (w_a_waddr),
        .i_wr_data (w_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_a_raddr),
        .o_rd_data (w_a_data)
    );

    dmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (B_DEPTH)
    ) u_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_b_we),
        .i_wr_addr (w_b_waddr),
        .i_wr_data (w_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_b_raddr),
        .o_rd_data (w_b_data)
    );

    assign w_last_i = (RCW'(r_i) + RCW'(1)) == r_rows;
    assign w_last_j = (CCW'(r_j) + CCW'(1)) == r_cols;
    assign w_last_k = (DCW'(r_k) + DCW'(1)) == r_depth;

    // Sequencer: walk i, j, k and issue one MAC step per advancing cycle
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        w_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_op == OP_START)) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    w_issue = 1'b1;
                    if (w_last_k) begin
                        n_k = '0;
                        if (w_last_j) begin
                            n_j = '0;
                            if (w_last_i) begin
                                n_state = ST_DRAIN;
                            end else begin
                                n_i = r_i + RB'(1);
                            end
                        end else begin
                            n_j = r_j + CB'(1);
                        end
                    end else begin
                        n_k = r_k + DB'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // Return to idle once the last step has left the MAC
                if (!r_s1.valid && !r_s2.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_tag.valid  = 1'b1;
        w_tag.first  = (r_k == '0);
        w_tag.lastk  = w_last_k;
        w_tag.lastel = w_last_i && w_last_j;
        w_tag.row    = POS_BITS'(r_i);
        w_tag.col    = POS_BITS'(r_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (w_adv) begin
                r_s1        <= w_issue ? w_tag : '0;
                r_s2        <= r_s1;
                r_out_valid <= r_s2.valid && r_s2.lastk;
            end
        end
    end

    // Accumulate: restart on the first step of each C element
    assign w_prod_wide = 64'(r_prod);
    assign w_sum = (r_s2.first ? '0 : r_acc) + w_prod_wide[SUM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= $signed(w_a_data) * $signed(w_b_data);
            if (r_s2.valid) begin
                r_acc <= w_sum;
            end
            if (r_s2.valid && r_s2.lastk) begin
                r_out_row  <= r_s2.row;
                r_out_col  <= r_s2.col;
                r_out_sum  <= w_sum;
                r_out_last <= r_s2.lastel;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_sum, r_out_col, r_out_row});

    // Keep the packed result width tied to its fields
    if (OUT_B > OUT_W) begin : g_width_check
        $error("result fields exceed tdata width");
    end

endmodule
